// ----- rtl/ajb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and state encoding for the adaptive jitter buffer.
package ajb_pkg;

    // Default slot depth of the descriptor store
    localparam int MAX_DEPTH_DEF = 16;

    // Width of the held-entry count, fixed by the queue_count port
    localparam int CNT_W = 5;

    // Configuration register indexes
    localparam logic [1:0] REG_MIN_DELAY = 2'd0;
    localparam logic [1:0] REG_MAX_DELAY = 2'd1;
    localparam logic [1:0] REG_MAX_QUEUE = 2'd2;

    // Configuration reset values
    localparam logic [15:0] MIN_DELAY_RST = 16'd40;
    localparam logic [15:0] MAX_DELAY_RST = 16'd200;
    localparam logic [4:0]  MAX_QUEUE_RST = 5'd8;

    // Target delay arithmetic in 1/65536 ms: loss*20 = loss*16 + loss*4,
    // jitter in 1/16 ms scales by 2*4096 = 8192
    localparam int LOSS_SH_HI = 4;
    localparam int LOSS_SH_LO = 2;
    localparam int JIT_SH     = 13;
    localparam int FRAC_SH    = 16;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_STATS = 2'd2,
        OP_FLUSH = 2'd3
    } opcode_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DROP,
        ST_INS_RD,
        ST_INS_CMP,
        ST_POP_RD,
        ST_POP_AGE,
        ST_POP_CMP,
        ST_ST_MUL,
        ST_ST_JIT,
        ST_ST_MIN,
        ST_ST_HI,
        ST_ST_CLAMP,
        ST_DONE
    } state_t;

    // One stored frame descriptor
    typedef struct packed {
        logic [31:0] frame_id;
        logic [63:0] timestamp;
        logic        keyframe;
        logic [31:0] arrival;
    } entry_t;

    typedef struct packed {
        alu_op_t     op;
        logic [63:0] a;
        logic [63:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [63:0] sum;
        logic        ge;
    } alu_rsp_t;

    // Configuration as seen by the sequencer
    typedef struct packed {
        logic [15:0]      min_delay;
        logic [15:0]      max_delay;
        logic [CNT_W-1:0] cap;
        logic [CNT_W-1:0] half;
        logic             min_load;
        logic [15:0]      min_wdata;
    } cfg_t;

endpackage

// ----- rtl/ajb_alu.sv -----
`timescale 1ns / 1ps
// Shared 64-bit add/subtract unit with unsigned greater-or-equal flag.
module ajb_alu
    import ajb_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [63:0] b_op;
    logic [64:0] total;

    // Subtract as a plus inverted b plus one; carry out means a >= b
    assign b_op  = (req.op == ALU_SUB) ? ~req.b : req.b;
    assign total = {1'b0, req.a} + {1'b0, b_op} + {64'd0, (req.op == ALU_SUB)};

    assign rsp.sum = total[63:0];
    assign rsp.ge  = total[64];

endmodule

// ----- rtl/ajb_store.sv -----
`timescale 1ns / 1ps
// Descriptor memory: one write port, one read port with registered data.
module ajb_store
    import ajb_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_DEPTH)-1:0] wr_addr,
    input  entry_t                       wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_DEPTH)-1:0] rd_addr,
    output entry_t                       rd_data
);

    entry_t mem [MAX_DEPTH];

    // Write one slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one slot, hold the word until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/ajb_seq.sv -----
`timescale 1ns / 1ps
// Sequencer: drives the shared unit and the store through push, pop, stats and flush.
module ajb_seq
    import ajb_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [1:0]                   opcode,
    input  logic [31:0]                  now_ms,
    input  logic [31:0]                  frame_id,
    input  logic [63:0]                  timestamp_us,
    input  logic                         is_keyframe,
    input  logic [15:0]                  jitter_sixteenths,
    input  logic [15:0]                  loss_fraction,
    input  cfg_t                         cfg,
    output logic                         busy,
    output logic                         done,
    output logic                         frame_valid,
    output entry_t                       frame_out,
    output logic                         idr_request,
    output logic [CNT_W-1:0]             queue_count,
    output logic [31:0]                  dropped_total,
    output logic [15:0]                  target_delay_ms,
    output logic                         mem_wr_en,
    output logic [$clog2(MAX_DEPTH)-1:0] mem_wr_addr,
    output entry_t                       mem_wr_data,
    output logic                         mem_rd_en,
    output logic [$clog2(MAX_DEPTH)-1:0] mem_rd_addr,
    input  entry_t                       mem_rd_data,
    output alu_req_t                     alu_req,
    input  alu_rsp_t                     alu_rsp
);

    localparam int AW = $clog2(MAX_DEPTH);
    localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;

    state_t           state_reg, state_next;
    opcode_t          op_in;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [AW-1:0]    head_reg, head_next, head_adv;
    logic [31:0]      drops_reg, drops_next;
    logic [15:0]      target_reg, target_next;
    logic             await_reg, await_next;
    entry_t           new_reg, new_next;
    logic [15:0]      jit_reg, jit_next;
    logic [15:0]      loss_reg, loss_next;
    logic [31:0]      acc_reg, acc_next;
    logic [15:0]      hi_reg, hi_next;
    logic [31:0]      age_reg, age_next;
    logic             fv_reg, fv_next;
    entry_t           frm_reg, frm_next;
    logic             idr_reg, idr_next;
    logic             done_reg, done_next;
    logic             full;
    logic             accept;

    // Map a queue position to a physical slot of the ring
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CNT_W-1:0] off);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(off);
        if (s >= SW'(MAX_DEPTH))
        begin
            s = s - SW'(MAX_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign op_in    = opcode_t'(opcode);
    assign accept   = start && (state_reg == ST_IDLE);
    assign full     = (held_reg >= cfg.cap);
    assign head_adv = (head_reg == AW'(MAX_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (op_in)
                        OP_PUSH:  state_next = (await_reg && !is_keyframe) ? ST_DONE : ST_DROP;
                        OP_POP:   state_next = (held_reg == '0) ? ST_DONE : ST_POP_RD;
                        OP_STATS: state_next = ST_ST_MUL;
                        OP_FLUSH: state_next = ST_DONE;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_DROP:     state_next = full ? ST_DROP : ST_INS_RD;
            ST_INS_RD:   state_next = (idx_reg == '0) ? ST_DONE : ST_INS_CMP;
            ST_INS_CMP:  state_next = alu_rsp.ge ? ST_INS_RD : ST_DONE;
            ST_POP_RD:   state_next = ST_POP_AGE;
            ST_POP_AGE:  state_next = ST_POP_CMP;
            ST_POP_CMP:  state_next = ST_DONE;
            ST_ST_MUL:   state_next = ST_ST_JIT;
            ST_ST_JIT:   state_next = ST_ST_MIN;
            ST_ST_MIN:   state_next = ST_ST_HI;
            ST_ST_HI:    state_next = ST_ST_CLAMP;
            ST_ST_CLAMP: state_next = ST_DONE;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Store and shared unit controls
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = new_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        alu_req.op  = ALU_SUB;
        alu_req.a   = '0;
        alu_req.b   = '0;
        case (state_reg)
            ST_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = phys(head_reg, '0);
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = phys(head_reg, idx_reg - 1'b1);
                end
            end
            ST_INS_CMP:
            begin
                // Move the entry up while its timestamp is not below the new one
                alu_req.a   = mem_rd_data.timestamp;
                alu_req.b   = new_reg.timestamp;
                mem_wr_en   = 1'b1;
                mem_wr_addr = phys(head_reg, idx_reg);
                mem_wr_data = alu_rsp.ge ? mem_rd_data : new_reg;
            end
            ST_POP_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = head_reg;
            end
            ST_POP_AGE:
            begin
                alu_req.a = {32'd0, new_reg.arrival};
                alu_req.b = {32'd0, mem_rd_data.arrival};
            end
            ST_POP_CMP:
            begin
                alu_req.a = {32'd0, age_reg};
                alu_req.b = {48'd0, target_reg};
            end
            ST_ST_MUL:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = {48'd0, loss_reg} << LOSS_SH_HI;
                alu_req.b  = {48'd0, loss_reg} << LOSS_SH_LO;
            end
            ST_ST_JIT:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = {32'd0, acc_reg};
                alu_req.b  = {48'd0, jit_reg} << JIT_SH;
            end
            ST_ST_MIN:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = {32'd0, acc_reg} >> FRAC_SH;
                alu_req.b  = {48'd0, cfg.min_delay};
            end
            ST_ST_HI:
            begin
                alu_req.a = {48'd0, cfg.max_delay};
                alu_req.b = {48'd0, cfg.min_delay};
            end
            ST_ST_CLAMP:
            begin
                alu_req.a = {48'd0, hi_reg};
                alu_req.b = {32'd0, acc_reg};
            end
            default:
            begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    // Working register updates
    always_comb
    begin
        idx_next    = idx_reg;
        held_next   = held_reg;
        head_next   = head_reg;
        drops_next  = drops_reg;
        target_next = target_reg;
        await_next  = await_reg;
        new_next    = new_reg;
        jit_next    = jit_reg;
        loss_next   = loss_reg;
        acc_next    = acc_reg;
        hi_next     = hi_reg;
        age_next    = age_reg;
        fv_next     = fv_reg;
        frm_next    = frm_reg;
        idr_next    = idr_reg;
        done_next   = 1'b0;

        // Writing the lower clamp also loads the target delay
        if (cfg.min_load)
        begin
            target_next = cfg.min_wdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    new_next.frame_id  = frame_id;
                    new_next.timestamp = timestamp_us;
                    new_next.keyframe  = is_keyframe;
                    new_next.arrival   = now_ms;
                    jit_next           = jitter_sixteenths;
                    loss_next          = loss_fraction;
                    fv_next            = 1'b0;
                    frm_next           = '0;
                    idr_next           = 1'b0;
                    case (op_in)
                        OP_PUSH:
                        begin
                            if (await_reg && !is_keyframe)
                            begin
                                idr_next = 1'b1;
                            end
                            else
                            begin
                                await_next = 1'b0;
                            end
                        end
                        OP_FLUSH:
                        begin
                            held_next  = '0;
                            await_next = 1'b1;
                        end
                        default:
                        begin
                            idr_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_DROP:
            begin
                // Drop the oldest entry while the queue is at capacity
                if (full)
                begin
                    head_next  = head_adv;
                    held_next  = held_reg - 1'b1;
                    drops_next = drops_reg + 32'd1;
                end
                else
                begin
                    idx_next = held_reg;
                end
            end
            ST_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    held_next = held_reg + 1'b1;
                end
            end
            ST_INS_CMP:
            begin
                if (alu_rsp.ge)
                begin
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    held_next = held_reg + 1'b1;
                end
            end
            ST_POP_AGE:
            begin
                age_next = alu_rsp.sum[31:0];
            end
            ST_POP_CMP:
            begin
                // Release the head once aged or once the queue is half full
                if (alu_rsp.ge || (held_reg >= cfg.half))
                begin
                    fv_next   = 1'b1;
                    frm_next  = mem_rd_data;
                    head_next = head_adv;
                    held_next = held_reg - 1'b1;
                end
            end
            ST_ST_MUL:
            begin
                acc_next = alu_rsp.sum[31:0];
            end
            ST_ST_JIT:
            begin
                acc_next = alu_rsp.sum[31:0];
            end
            ST_ST_MIN:
            begin
                acc_next = alu_rsp.sum[31:0];
            end
            ST_ST_HI:
            begin
                hi_next = alu_rsp.ge ? cfg.max_delay : cfg.min_delay;
            end
            ST_ST_CLAMP:
            begin
                target_next = alu_rsp.ge ? acc_reg[15:0] : hi_reg;
            end
            ST_DONE:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            held_reg   <= '0;
            head_reg   <= '0;
            drops_reg  <= '0;
            target_reg <= MIN_DELAY_RST;
            await_reg  <= 1'b1;
            fv_reg     <= 1'b0;
            idr_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            held_reg   <= held_next;
            head_reg   <= head_next;
            drops_reg  <= drops_next;
            target_reg <= target_next;
            await_reg  <= await_next;
            fv_reg     <= fv_next;
            idr_reg    <= idr_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        new_reg  <= new_next;
        jit_reg  <= jit_next;
        loss_reg <= loss_next;
        acc_reg  <= acc_next;
        hi_reg   <= hi_next;
        age_reg  <= age_next;
        frm_reg  <= frm_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign frame_valid     = fv_reg;
    assign frame_out       = frm_reg;
    assign idr_request     = idr_reg;
    assign queue_count     = held_reg;
    assign dropped_total   = drops_reg;
    assign target_delay_ms = target_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(held_reg) <= MAX_DEPTH)
        else $error("held count beyond store depth");

    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(fv_reg && idr_reg))
        else $error("frame emitted on a refused push");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted word left no work");

    a_drop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (drops_reg != $past(drops_reg)) |-> ($past(state_reg) == ST_DROP))
        else $error("drop count moved outside the drop phase");

    a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS_CMP) |-> (idx_reg != '0))
        else $error("insertion walk ran below the head");
`endif

endmodule

// ----- rtl/adaptive_jitter_buffer.sv -----
`timescale 1ns / 1ps
// Top level of the adaptive jitter buffer: configuration registers, store, unit, sequencer.
//
//  channel   handshake            payload
//  -------   ------------------   ------------------------------------------------
//  command   start / busy         opcode, now_ms, frame_id, timestamp_us,
//                                 is_keyframe, jitter_sixteenths, loss_fraction
//  result    done (one cycle)     frame_valid, out_frame_id, out_timestamp_us,
//                                 out_keyframe, idr_request, queue_count,
//                                 dropped_total, target_delay_ms
//  config    cfg_we               cfg_index, cfg_wdata
//
// A word is taken when start is high and busy low; done pulses for one cycle
// with the result. A push drops the oldest entries while the queue is full,
// then moves entries up, one store access per step, until the new one fits.
// Compares, ages and the target delay are worked out in one shared 64-bit
// add/subtract unit. Reset is asynchronous, active low, and leaves an empty
// queue with the keyframe gate armed. The receiver cannot stall; a new
// command may be accepted in the cycle done is high.
module adaptive_jitter_buffer
    import ajb_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic [1:0]  opcode,
    input  logic [31:0] now_ms,
    input  logic [31:0] frame_id,
    input  logic [63:0] timestamp_us,
    input  logic        is_keyframe,
    input  logic [15:0] jitter_sixteenths,
    input  logic [15:0] loss_fraction,
    output logic        frame_valid,
    output logic [31:0] out_frame_id,
    output logic [63:0] out_timestamp_us,
    output logic        out_keyframe,
    output logic        idr_request,
    output logic [4:0]  queue_count,
    output logic [31:0] dropped_total,
    output logic [15:0] target_delay_ms
);

    localparam int AW = $clog2(MAX_DEPTH);

    localparam logic [CNT_W-1:0] DEPTH_CAP =
        (MAX_DEPTH > 31) ? CNT_W'(31) : CNT_W'(MAX_DEPTH);

    logic [15:0]      min_reg;
    logic [15:0]      max_reg;
    logic [4:0]       mq_reg;
    logic [CNT_W-1:0] cap;
    cfg_t             cfg;

    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    entry_t           mem_wr_data;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    entry_t           mem_rd_data;
    alu_req_t         alu_req;
    alu_rsp_t         alu_rsp;
    entry_t           frame_out;

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_DELAY_RST;
            max_reg <= MAX_DELAY_RST;
            mq_reg  <= MAX_QUEUE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_DELAY: min_reg <= cfg_wdata;
                REG_MAX_DELAY: max_reg <= cfg_wdata;
                REG_MAX_QUEUE: mq_reg  <= cfg_wdata[4:0];
                default:       mq_reg  <= mq_reg;
            endcase
        end
    end

    // Clamp the capacity in use to at least one and at most the store depth and 31
    always_comb
    begin
        if (mq_reg == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (mq_reg > DEPTH_CAP)
        begin
            cap = DEPTH_CAP;
        end
        else
        begin
            cap = mq_reg;
        end
    end

    assign cfg.min_delay = min_reg;
    assign cfg.max_delay = max_reg;
    assign cfg.cap       = cap;
    assign cfg.half      = cap >> 1;
    assign cfg.min_load  = cfg_we && (cfg_index == REG_MIN_DELAY);
    assign cfg.min_wdata = cfg_wdata;

    ajb_store #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ajb_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    ajb_seq #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .opcode            (opcode),
        .now_ms            (now_ms),
        .frame_id          (frame_id),
        .timestamp_us      (timestamp_us),
        .is_keyframe       (is_keyframe),
        .jitter_sixteenths (jitter_sixteenths),
        .loss_fraction     (loss_fraction),
        .cfg               (cfg),
        .busy              (busy),
        .done              (done),
        .frame_valid       (frame_valid),
        .frame_out         (frame_out),
        .idr_request       (idr_request),
        .queue_count       (queue_count),
        .dropped_total     (dropped_total),
        .target_delay_ms   (target_delay_ms),
        .mem_wr_en         (mem_wr_en),
        .mem_wr_addr       (mem_wr_addr),
        .mem_wr_data       (mem_wr_data),
        .mem_rd_en         (mem_rd_en),
        .mem_rd_addr       (mem_rd_addr),
        .mem_rd_data       (mem_rd_data),
        .alu_req           (alu_req),
        .alu_rsp           (alu_rsp)
    );

    // Emitted frame fields
    assign out_frame_id     = frame_out.frame_id;
    assign out_timestamp_us = frame_out.timestamp;
    assign out_keyframe     = frame_out.keyframe;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the adaptive jitter buffer: directed cases, then random traffic.
module tb
    import ajb_pkg::*;
();

    // Register index with no register behind it
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int SLOT_DEPTH  = MAX_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_ERROR_LINES = 100;

    typedef struct packed {
        opcode_t     op;
        logic [31:0] now;
        logic [31:0] id;
        logic [63:0] ts;
        logic        key;
        logic [15:0] jit;
        logic [15:0] loss;
    } command_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] id;
        logic [63:0] ts;
        logic        key;
        logic        idr;
        logic [4:0]  count;
        logic [31:0] drops;
        logic [15:0] target;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [31:0] frame_id;
    logic [63:0] timestamp_us;
    logic        is_keyframe;
    logic [15:0] jitter_sixteenths;
    logic [15:0] loss_fraction;
    logic        frame_valid;
    logic [31:0] out_frame_id;
    logic [63:0] out_timestamp_us;
    logic        out_keyframe;
    logic        idr_request;
    logic [4:0]  queue_count;
    logic [31:0] dropped_total;
    logic [15:0] target_delay_ms;

    // Shadow copy of the buffer state and its registers
    entry_t      shadow_slots[$];
    logic [15:0] shadow_target;
    logic [31:0] shadow_drops;
    logic        shadow_await_key;
    logic [15:0] shadow_min;
    logic [15:0] shadow_max;
    logic [4:0]  shadow_cap_reg;

    frame_result_t pending_results[$];
    frame_result_t want_result;
    int unsigned   error_count = 0;
    int unsigned   stall_cycles = 0;
    int unsigned   gap_max = 10;
    logic [31:0]   clock_ms;
    logic [63:0]   last_ts;

    adaptive_jitter_buffer dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .done              (done),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .opcode            (opcode),
        .now_ms            (now_ms),
        .frame_id          (frame_id),
        .timestamp_us      (timestamp_us),
        .is_keyframe       (is_keyframe),
        .jitter_sixteenths (jitter_sixteenths),
        .loss_fraction     (loss_fraction),
        .frame_valid       (frame_valid),
        .out_frame_id      (out_frame_id),
        .out_timestamp_us  (out_timestamp_us),
        .out_keyframe      (out_keyframe),
        .idr_request       (idr_request),
        .queue_count       (queue_count),
        .dropped_total     (dropped_total),
        .target_delay_ms   (target_delay_ms)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Work out the result word of one command and advance the shadow state
    function automatic frame_result_t predict_frame_result(input command_t c);
        frame_result_t r;
        int unsigned   cap;
        int unsigned   pos;
        logic [31:0]   age;
        logic [63:0]   raw;
        logic [63:0]   whole_ms;
        logic [15:0]   upper;
        entry_t        e;
        r = '0;
        cap = 32'(shadow_cap_reg);
        if (cap < 1)
            cap = 1;
        if (cap > SLOT_DEPTH)
            cap = SLOT_DEPTH;
        case (c.op)
            OP_PUSH:
            begin
                if (shadow_await_key && !c.key)
                    r.idr = 1'b1;
                else
                begin
                    shadow_await_key = 1'b0;
                    // drop the earliest entries until there is room
                    while (shadow_slots.size() >= cap)
                    begin
                        shadow_slots.delete(0);
                        shadow_drops = shadow_drops + 32'd1;
                    end
                    pos = 0;
                    while (pos < shadow_slots.size() && shadow_slots[pos].timestamp < c.ts)
                        pos++;
                    e.frame_id  = c.id;
                    e.timestamp = c.ts;
                    e.keyframe  = c.key;
                    e.arrival   = c.now;
                    shadow_slots.insert(pos, e);
                end
            end
            OP_POP:
            begin
                if (shadow_slots.size() > 0)
                begin
                    age = c.now - shadow_slots[0].arrival;
                    if (age >= {16'd0, shadow_target} || shadow_slots.size() >= cap / 2)
                    begin
                        r.valid = 1'b1;
                        r.id    = shadow_slots[0].frame_id;
                        r.ts    = shadow_slots[0].timestamp;
                        r.key   = shadow_slots[0].keyframe;
                        shadow_slots.delete(0);
                    end
                end
            end
            OP_STATS:
            begin
                upper = (shadow_max < shadow_min) ? shadow_min : shadow_max;
                raw = (64'(shadow_min) << 16) + 64'(c.jit) * 64'd8192 + 64'(c.loss) * 64'd20;
                whole_ms = raw >> 16;
                if (whole_ms < 64'(shadow_min))
                    whole_ms = 64'(shadow_min);
                if (whole_ms > 64'(upper))
                    whole_ms = 64'(upper);
                shadow_target = whole_ms[15:0];
            end
            default:
            begin
                shadow_slots.delete();
                shadow_await_key = 1'b1;
            end
        endcase
        r.count  = 5'(shadow_slots.size());
        r.drops  = shadow_drops;
        r.target = shadow_target;
        return r;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_ERROR_LINES)
            $display("error at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // Send one command word after a random gap and record its expected result
    task automatic issue_command(input opcode_t op, input logic [31:0] now,
                                 input logic [31:0] id, input logic [63:0] ts,
                                 input logic key, input logic [15:0] jit,
                                 input logic [15:0] loss);
        int unsigned gap;
        command_t    c;
        gap    = $urandom_range(0, gap_max);
        c.op   = op;
        c.now  = now;
        c.id   = id;
        c.ts   = ts;
        c.key  = key;
        c.jit  = jit;
        c.loss = loss;
        @(negedge clk);
        if (gap != 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode            = op;
        now_ms            = now;
        frame_id          = id;
        timestamp_us      = ts;
        is_keyframe       = key;
        jitter_sixteenths = jit;
        loss_fraction     = loss;
        start             = 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_frame_result(c));
    endtask

    // Hold the sender until every outstanding word has come back
    task automatic wait_drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write one register; only called with the block idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        start     = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_MIN_DELAY:
            begin
                shadow_min    = value;
                shadow_target = value;
            end
            REG_MAX_DELAY: shadow_max = value;
            REG_MAX_QUEUE: shadow_cap_reg = value[4:0];
            default: ;
        endcase
    endtask

    task automatic test_keyframe_gate();
        issue_command(OP_PUSH, 32'd1000, 32'h0000_0001, 64'd500, 1'b0, 16'd0, 16'd0);
        issue_command(OP_POP, 32'd1000, 32'd0, 64'd0, 1'b0, 16'd0, 16'd0);
        issue_command(OP_PUSH, 32'd1000, 32'hFFFF_FFFF, 64'd500, 1'b1, 16'd0, 16'd0);
        // equal timestamp: new word goes ahead of the held one
        issue_command(OP_PUSH, 32'd1001, 32'h0000_0002, 64'd500, 1'b0, 16'd0, 16'd0);
    endtask

    task automatic test_sort_order();
        issue_command(OP_PUSH, 32'd1002, 32'h0000_0003, 64'd0, 1'b0, 16'd0, 16'd0);
        issue_command(OP_PUSH, 32'd1002, 32'h0000_0004, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                      16'd0, 16'd0);
        issue_command(OP_PUSH, 32'd1002, 32'h0000_0005, 64'd250, 1'b0, 16'd0, 16'd0);
    endtask

    task automatic test_pop_timing();
        wait_drain();
        write_reg(REG_MAX_QUEUE, 16'd16);
        // one short of the target age, then exactly on it
        issue_command(OP_POP, 32'd1002, 32'd0, 64'd0, 1'b0, 16'd0, 16'd0);
        issue_command(OP_POP, 32'd1041, 32'd0, 64'd0, 1'b0, 16'd0, 16'd0);
        issue_command(OP_POP, 32'd1042, 32'd0, 64'd0, 1'b0, 16'd0, 16'd0);
        // clock behind the arrival: age wraps to a huge value
        issue_command(OP_POP, 32'd1001, 32'd0, 64'd0, 1'b0, 16'd0, 16'd0);
    endtask

    task automatic test_overflow_drop();
        wait_drain();
        write_reg(REG_MAX_QUEUE, 16'd2);
        issue_command(OP_PUSH, 32'd2000, 32'h0000_0010, 64'd1, 1'b1, 16'd0, 16'd0);
        issue_command(OP_PUSH, 32'd2001, 32'h0000_0011, 64'd1, 1'b0, 16'd0, 16'd0);
    endtask

    task automatic test_target_delay();
        wait_drain();
        write_reg(REG_MIN_DELAY, 16'd0);
        write_reg(REG_MAX_DELAY, 16'hFFFF);
        issue_command(OP_STATS, 32'd2002, 32'd0, 64'd0, 1'b0, 16'd0, 16'd0);
        issue_command(OP_STATS, 32'd2002, 32'd0, 64'd0, 1'b0, 16'hFFFF, 16'hFFFF);
        // upper clamp below the lower one acts as the lower one
        wait_drain();
        write_reg(REG_MAX_DELAY, 16'd0);
        write_reg(REG_MIN_DELAY, 16'd100);
        issue_command(OP_STATS, 32'd2003, 32'd0, 64'd0, 1'b0, 16'd1000, 16'd0);
        wait_drain();
        write_reg(REG_MIN_DELAY, 16'hFFFF);
        issue_command(OP_STATS, 32'd2003, 32'd0, 64'd0, 1'b0, 16'd0, 16'hFFFF);
    endtask

    task automatic test_capacity_extremes();
        // capacity zero acts as one, and then every pop is forced
        wait_drain();
        write_reg(REG_MAX_QUEUE, 16'd0);
        issue_command(OP_PUSH, 32'd3000, 32'h0000_0020, 64'd7, 1'b1, 16'd0, 16'd0);
        issue_command(OP_PUSH, 32'd3000, 32'h0000_0021, 64'd9, 1'b1, 16'd0, 16'd0);
        issue_command(OP_POP, 32'd3000, 32'd0, 64'd0, 1'b0, 16'd0, 16'd0);
    endtask

    task automatic test_flush();
        issue_command(OP_PUSH, 32'd3001, 32'h0000_0030, 64'd3, 1'b1, 16'd0, 16'd0);
        issue_command(OP_FLUSH, 32'd3001, 32'd0, 64'd0, 1'b0, 16'd0, 16'd0);
        issue_command(OP_PUSH, 32'd3002, 32'h0000_0031, 64'd4, 1'b0, 16'd0, 16'd0);
    endtask

    // Mostly well-formed traffic with an advancing clock that sometimes jumps, some noise words
    task automatic run_traffic_phase(input logic [15:0] min_d, input logic [15:0] max_d,
                                     input logic [15:0] cap_w, input int unsigned gap_top,
                                     input int words);
        int unsigned pick;
        int unsigned ts_pick;
        int          i;
        logic [63:0] ts;
        wait_drain();
        write_reg(REG_MIN_DELAY, min_d);
        write_reg(REG_MAX_DELAY, max_d);
        write_reg(REG_MAX_QUEUE, cap_w);
        gap_max = gap_top;
        for (i = 0; i < words; i++)
        begin
            if (i == words / 2 || $urandom_range(0, 49) == 0)
                wait_drain();
            clock_ms += $urandom_range(0, 40);
            if ($urandom_range(0, 19) == 0)
                clock_ms += $urandom_range(0, 20000);
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                ts_pick = $urandom_range(0, 9);
                if (ts_pick == 0)
                    ts = last_ts;
                else if (ts_pick < 3)
                    ts = last_ts - 64'($urandom_range(0, 100000));
                else
                begin
                    ts = last_ts + 64'($urandom_range(1, 66000));
                    last_ts = ts;
                end
                issue_command(OP_PUSH, clock_ms, $urandom, ts, $urandom_range(0, 3) == 0,
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            end
            else if (pick < 75)
                issue_command(OP_POP, clock_ms, $urandom, {$urandom, $urandom},
                              1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)));
            else if (pick < 83)
                issue_command(OP_STATS, clock_ms, $urandom, {$urandom, $urandom},
                              1'($urandom_range(0, 1)), 16'($urandom_range(0, 2000)),
                              16'($urandom_range(0, 6000)));
            else if (pick < 86)
                issue_command(OP_FLUSH, clock_ms, $urandom, {$urandom, $urandom},
                              1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)));
            else
                issue_command(opcode_t'($urandom_range(0, 3)), $urandom, $urandom,
                              {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic test_random_traffic();
        clock_ms = 32'hFFFF_F000;
        last_ts  = 64'd1_000_000;
        run_traffic_phase(16'd40, 16'd200, 16'd8, 10, 75);
        run_traffic_phase(16'd0, 16'hFFFF, 16'd16, 0, 75);
        run_traffic_phase(16'hFFFF, 16'd0, 16'd1, 10, 75);
        run_traffic_phase(16'd10, 16'd30, 16'd4, 0, 75);
        // unused register index must be ignored
        wait_drain();
        write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
        run_traffic_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                          16'd31, 10, 75);
        run_traffic_phase(16'($urandom_range(0, 300)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), $urandom_range(0, 10), 75);
    endtask

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_error("result word with no command outstanding");
            else
            begin
                want_result = pending_results[0];
                pending_results.delete(0);
                check_field("frame_valid", 64'(frame_valid), 64'(want_result.valid));
                check_field("out_frame_id", 64'(out_frame_id), 64'(want_result.id));
                check_field("out_timestamp_us", out_timestamp_us, want_result.ts);
                check_field("out_keyframe", 64'(out_keyframe), 64'(want_result.key));
                check_field("idr_request", 64'(idr_request), 64'(want_result.idr));
                check_field("queue_count", 64'(queue_count), 64'(want_result.count));
                check_field("dropped_total", 64'(dropped_total), 64'(want_result.drops));
                check_field("target_delay_ms", 64'(target_delay_ms), 64'(want_result.target));
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        start             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_MIN_DELAY;
        cfg_wdata         = 16'd0;
        opcode            = OP_PUSH;
        now_ms            = 32'd0;
        frame_id          = 32'd0;
        timestamp_us      = 64'd0;
        is_keyframe       = 1'b0;
        jitter_sixteenths = 16'd0;
        loss_fraction     = 16'd0;
        shadow_slots.delete();
        shadow_target    = MIN_DELAY_RST;
        shadow_drops     = 32'd0;
        shadow_await_key = 1'b1;
        shadow_min       = MIN_DELAY_RST;
        shadow_max       = MAX_DELAY_RST;
        shadow_cap_reg   = MAX_QUEUE_RST;
        clock_ms         = 32'd0;
        last_ts          = 64'd0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_keyframe_gate();
        test_sort_order();
        test_pop_timing();
        test_overflow_drop();
        test_target_delay();
        test_capacity_extremes();
        test_flush();
        test_random_traffic();

        // let the last words come back, then allow for stragglers
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
